@@ hw/rtl/whl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wake latency histogram package
// Operation and register codes, result kinds and the statistics records
// shared by the histogram monitor modules.
// ----------------------------------------------------------------------------
package whl_pkg;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_ARM    = 2'd2;

   localparam logic [1:0] CSR_LATENCY_SHIFT = 2'd0;
   localparam logic [1:0] CSR_BINS_IN_USE   = 2'd1;
   localparam logic [1:0] CSR_PERIOD_NS     = 2'd2;

   localparam logic [5:0]  SHIFT_RESET  = 6'd16;
   localparam logic [8:0]  BINS_RESET   = 9'd200;
   localparam logic [39:0] PERIOD_RESET = 40'd100000000;
   localparam logic [63:0] ARM_LEAD_NS  = 64'd100000000;
   localparam logic [31:0] LEAST_RESET  = 32'd100000000;
   localparam logic [30:0] GAP_LIMIT    = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      OUTCOME_UNDERRUN = 3'd0,
      OUTCOME_BINNED   = 3'd1,
      OUTCOME_OVERRUN  = 3'd2,
      OUTCOME_READBACK = 3'd3,
      OUTCOME_ARMED    = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [31:0] least;
      logic [31:0] greatest;
      logic [31:0] early;
      logic [31:0] late;
      logic [30:0] widest_gap;
   } stats_type;

   typedef struct packed {
      logic        sample;
      logic        positive;
      logic        overrun;
      logic [31:0] sat_latency;
      logic        gap_ok;
      logic [30:0] gap;
   } stats_update_type;

   typedef struct packed {
      logic bump;
      logic show;
   } hist_ctrl_type;

endpackage

@@ hw/rtl/wake_latency_histogram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wake latency histogram
// Measures periodic wake-up latency against an armed schedule and keeps a
// histogram of shifted latencies together with running statistics.
// ----------------------------------------------------------------------------
// The req channel carries one item per transfer: a sample, a bin read or an
// arm command, selected by req_tuser. Every item gives exactly one result on
// the rsp channel, in order, holding the outcome and the statistics as they
// stand after that item. Registers are written through the csr port; the user
// must do so only while the block is idle, which the block does not enforce.
// A result passes through the s1, s2 and output registers: the input stage
// forms the latency and read gap, the classification stage classifies and
// addresses the bin RAM, and the s2 stage increments the bin with forwarding
// from the preceding write. One item is accepted every cycle, outside the
// clearing pass and while the receiver does not stall; the bin RAM
// read-modify-write sets that. Reset restores the registers and statistics
// and starts a clearing pass over all MAX_BINS bins, with req_tready low.
// When rsp_tready is low the held result waits in the output register and
// the whole pipeline stops; outside the clearing pass, req_tready drops only
// while a result is waiting and the receiver is stalling.
// ----------------------------------------------------------------------------
module wake_latency_histogram
   import whl_pkg::*;
#(
   parameter int MAX_BINS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_stamp_ns [63:0], second_stamp_ns [127:64], read_index [135:128]
   input  logic [135:0] req_tdata,
   // op [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // latency_ns [63:0], bin_number [71:64], bin_value [103:72],
   // min_latency [135:104], max_latency [167:136], underrun_total [199:168],
   // overrun_total [231:200], max_read_delay [262:232], zero [263]
   output logic [263:0] rsp_tdata,
   // outcome [2:0]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [39:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_BINS);

   logic [5:0]  latency_shift_ff, latency_shift_in;
   logic [8:0]  bins_in_use_ff, bins_in_use_in;
   logic [39:0] period_ns_ff, period_ns_in;
   logic [63:0] expected_wake_ff, expected_wake_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff, s1_op_in;
   logic [63:0] s1_diff_ff, s1_diff_in;
   logic        s1_gap_ok_ff, s1_gap_ok_in;
   logic [30:0] s1_gap_ff, s1_gap_in;
   logic [7:0]  s1_ridx_ff, s1_ridx_in;

   logic        s2_valid_ff, s2_valid_in;
   outcome_type s2_outcome_ff, s2_outcome_in;
   logic [63:0] s2_latency_ff, s2_latency_in;
   logic [7:0]  s2_bin_number_ff, s2_bin_number_in;
   stats_type   s2_stats_ff, s2_stats_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;
   logic [263:0] rsp_data_ff, rsp_data_in;

   logic        advance;
   logic        accept;
   logic        clear_busy;
   logic [63:0] first_stamp;
   logic [63:0] second_stamp;
   logic [63:0] gap;
   logic        is_sample;
   logic        positive;
   logic [63:0] slot;
   logic [63:0] limit;
   logic        overrun;
   logic        ridx_in_range;
   outcome_type outcome;
   stats_update_type stats_upd;
   stats_type   stats_next;
   hist_ctrl_type hist_ctrl;
   logic [AW-1:0] hist_addr;
   logic [31:0] bin_value;

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = advance && !clear_busy;
   assign accept       = req_tvalid && req_tready;
   assign first_stamp  = req_tdata[63:0];
   assign second_stamp = req_tdata[127:64];

   // Configuration registers.
   always_comb begin
      latency_shift_in = latency_shift_ff;
      bins_in_use_in   = bins_in_use_ff;
      period_ns_in     = period_ns_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LATENCY_SHIFT: latency_shift_in = csr_wdata[5:0];
            CSR_BINS_IN_USE:   bins_in_use_in   = csr_wdata[8:0];
            CSR_PERIOD_NS:     period_ns_in     = csr_wdata;
            default:           ;
         endcase
      end
   end

   // Input stage: latency against the schedule and the timestamp gap.
   always_comb begin
      gap = second_stamp - first_stamp;

      expected_wake_in = expected_wake_ff;
      s1_valid_in      = advance ? 1'b0 : s1_valid_ff;
      s1_op_in         = s1_op_ff;
      s1_diff_in       = s1_diff_ff;
      s1_gap_ok_in     = s1_gap_ok_ff;
      s1_gap_in        = s1_gap_ff;
      s1_ridx_in       = s1_ridx_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_op_in     = req_tuser;
         s1_diff_in   = first_stamp - expected_wake_ff;
         s1_gap_ok_in = !gap[63];
         s1_gap_in    = (|gap[62:31]) ? GAP_LIMIT : gap[30:0];
         s1_ridx_in   = req_tdata[135:128];
         if (req_tuser == OP_SAMPLE) begin
            expected_wake_in = expected_wake_ff + {24'd0, period_ns_ff};
         end else if (req_tuser == OP_ARM) begin
            expected_wake_in = first_stamp + ARM_LEAD_NS;
         end
      end
   end

   // Classification stage: bin selection, statistics and RAM addressing.
   always_comb begin
      is_sample     = (s1_op_ff == OP_SAMPLE);
      positive      = !((s1_diff_ff == 64'd0) || s1_diff_ff[63]);
      slot          = s1_diff_ff >> latency_shift_ff;
      limit         = ({55'd0, bins_in_use_ff} > 64'(MAX_BINS)) ? 64'(MAX_BINS)
                                                                : {55'd0, bins_in_use_ff};
      overrun       = (slot >= limit);
      ridx_in_range = ({24'd0, s1_ridx_ff} < 32'(MAX_BINS));

      if (is_sample) begin
         if (!positive) begin
            outcome = OUTCOME_UNDERRUN;
         end else if (overrun) begin
            outcome = OUTCOME_OVERRUN;
         end else begin
            outcome = OUTCOME_BINNED;
         end
      end else if (s1_op_ff == OP_ARM) begin
         outcome = OUTCOME_ARMED;
      end else begin
         outcome = OUTCOME_READBACK;
      end

      stats_upd.sample      = s1_valid_ff && is_sample;
      stats_upd.positive    = positive;
      stats_upd.overrun     = overrun;
      stats_upd.sat_latency = (|s1_diff_ff[63:32]) ? 32'hFFFF_FFFF : s1_diff_ff[31:0];
      stats_upd.gap_ok      = s1_gap_ok_ff;
      stats_upd.gap         = s1_gap_ff;

      hist_ctrl.bump = s1_valid_ff && (outcome == OUTCOME_BINNED);
      hist_ctrl.show = s1_valid_ff && (outcome == OUTCOME_READBACK) && ridx_in_range;
      hist_addr      = is_sample ? AW'(slot) : AW'(s1_ridx_ff);

      s2_valid_in      = s2_valid_ff;
      s2_outcome_in    = s2_outcome_ff;
      s2_latency_in    = s2_latency_ff;
      s2_bin_number_in = s2_bin_number_ff;
      s2_stats_in      = s2_stats_ff;
      if (advance) begin
         s2_valid_in   = s1_valid_ff;
         s2_outcome_in = outcome;
         s2_latency_in = is_sample ? s1_diff_ff : 64'd0;
         s2_stats_in   = stats_next;
         case (outcome)
            OUTCOME_BINNED:   s2_bin_number_in = slot[7:0];
            OUTCOME_READBACK: s2_bin_number_in = s1_ridx_ff;
            default:          s2_bin_number_in = 8'd0;
         endcase
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s2_valid_ff;
         rsp_user_in  = s2_outcome_ff;
         rsp_data_in  = {1'b0,
                         s2_stats_ff.widest_gap,
                         s2_stats_ff.late,
                         s2_stats_ff.early,
                         s2_stats_ff.greatest,
                         s2_stats_ff.least,
                         bin_value,
                         s2_bin_number_ff,
                         s2_latency_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_shift_ff <= SHIFT_RESET;
         bins_in_use_ff   <= BINS_RESET;
         period_ns_ff     <= PERIOD_RESET;
         expected_wake_ff <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         latency_shift_ff <= latency_shift_in;
         bins_in_use_ff   <= bins_in_use_in;
         period_ns_ff     <= period_ns_in;
         expected_wake_ff <= expected_wake_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      s1_op_ff         <= s1_op_in;
      s1_diff_ff       <= s1_diff_in;
      s1_gap_ok_ff     <= s1_gap_ok_in;
      s1_gap_ff        <= s1_gap_in;
      s1_ridx_ff       <= s1_ridx_in;
      s2_outcome_ff    <= s2_outcome_in;
      s2_latency_ff    <= s2_latency_in;
      s2_bin_number_ff <= s2_bin_number_in;
      s2_stats_ff      <= s2_stats_in;
      rsp_user_ff      <= rsp_user_in;
      rsp_data_ff      <= rsp_data_in;
   end

   whl_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .upd        (stats_upd),
      .stats_next (stats_next)
   );

   whl_hist #(
      .MAX_BINS (MAX_BINS)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctrl       (hist_ctrl),
      .addr       (hist_addr),
      .bin_value  (bin_value),
      .clear_busy (clear_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // No item may enter while the bin RAM is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("item accepted during histogram clearing pass");

   // Once a positive latency has been seen the minimum cannot exceed the maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_user_ff == OUTCOME_BINNED) || (rsp_user_ff == OUTCOME_OVERRUN))
      |-> (rsp_data_ff[135:104] <= rsp_data_ff[167:136]))
      else $error("minimum latency above maximum latency");

   // An underrun result carries a latency of zero or less.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff == OUTCOME_UNDERRUN)
      |-> (rsp_data_ff[63] || (rsp_data_ff[63:0] == 64'd0)))
      else $error("underrun reported for a positive latency");

   // A binned result always names a bin inside the configured range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff == OUTCOME_BINNED)
      |-> ({1'b0, rsp_data_ff[71:64]} < bins_in_use_ff) || (MAX_BINS > 256))
      else $error("binned result outside the bins in use");

endmodule

@@ hw/rtl/whl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data. A read of an
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module whl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/whl_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wake latency statistics
// Running minimum and maximum latency, underrun and overrun counts and the
// widest gap between the two timestamps of a sample.
// ----------------------------------------------------------------------------
module whl_stats
   import whl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  stats_update_type upd,
   output stats_type        stats_next
);

   stats_type stats_ff;
   stats_type stats_in;

   always_comb begin
      stats_in = stats_ff;
      if (upd.sample) begin
         if (upd.gap_ok && (upd.gap > stats_ff.widest_gap)) begin
            stats_in.widest_gap = upd.gap;
         end
         if (!upd.positive) begin
            stats_in.early = stats_ff.early + 32'd1;
         end else begin
            if (upd.sat_latency > stats_ff.greatest) begin
               stats_in.greatest = upd.sat_latency;
            end
            if (upd.sat_latency < stats_ff.least) begin
               stats_in.least = upd.sat_latency;
            end
            if (upd.overrun) begin
               stats_in.late = stats_ff.late + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff.least      <= LEAST_RESET;
         stats_ff.greatest   <= '0;
         stats_ff.early      <= '0;
         stats_ff.late       <= '0;
         stats_ff.widest_gap <= '0;
      end else if (enable) begin
         stats_ff <= stats_in;
      end
   end

   assign stats_next = stats_in;

endmodule

@@ hw/rtl/whl_hist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wake latency histogram store
// Bin counts in a RAM with a read, increment and write-back stage, a
// forwarding register for back-to-back hits on one bin and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module whl_hist
   import whl_pkg::*;
#(
   parameter int MAX_BINS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  hist_ctrl_type               ctrl,
   input  logic [$clog2(MAX_BINS)-1:0] addr,
   output logic [31:0]                 bin_value,
   output logic                        clear_busy
);

   localparam int AW = $clog2(MAX_BINS);

   logic          clear_busy_ff, clear_busy_in;
   logic [AW-1:0] clear_ptr_ff, clear_ptr_in;
   hist_ctrl_type s2_ctrl_ff, s2_ctrl_in;
   logic [AW-1:0] s2_addr_ff, s2_addr_in;
   logic          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_addr_ff, fwd_addr_in;
   logic [31:0]   fwd_data_ff, fwd_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [31:0]   ram_rdata;
   logic [31:0]   current;
   logic [31:0]   bumped;

   always_comb begin
      current = (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) ? fwd_data_ff : ram_rdata;
      bumped  = current + 32'd1;

      clear_busy_in = clear_busy_ff;
      clear_ptr_in  = clear_ptr_ff;
      if (clear_busy_ff) begin
         clear_ptr_in = clear_ptr_ff + AW'(1);
         if (clear_ptr_ff == AW'(MAX_BINS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end

      s2_ctrl_in   = s2_ctrl_ff;
      s2_addr_in   = s2_addr_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (advance) begin
         s2_ctrl_in   = ctrl;
         s2_addr_in   = addr;
         fwd_valid_in = s2_ctrl_ff.bump;
         fwd_addr_in  = s2_addr_ff;
         fwd_data_in  = bumped;
      end

      if (clear_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clear_ptr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = advance && s2_ctrl_ff.bump;
         ram_waddr = s2_addr_ff;
         ram_wdata = bumped;
      end

      if (s2_ctrl_ff.bump) begin
         bin_value = bumped;
      end else if (s2_ctrl_ff.show) begin
         bin_value = current;
      end else begin
         bin_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_ptr_ff  <= '0;
         s2_ctrl_ff    <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_ptr_ff  <= clear_ptr_in;
         s2_ctrl_ff    <= s2_ctrl_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
      s2_addr_ff  <= s2_addr_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   whl_ram #(
      .WIDTH (32),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (advance),
      .raddr (addr),
      .rdata (ram_rdata)
   );

   assign clear_busy = clear_busy_ff;

endmodule
